// ===== rtl/core/gsb_pkg.sv =====
// ----------------------------------------------------------------------------
// gsb_pkg
// Shared sizes, register codes, datapath operation codes and the
// command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package gsb_pkg;

    // history ring geometry
    localparam int CAPACITY   = 1024;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    // field widths
    localparam int RATE_W     = 16;
    localparam int WGT_W      = 8;
    localparam int LIM_W      = 15;
    localparam int FILL_W     = 11;
    localparam int ENTRY_W    = 3 * RATE_W;

    // running sum holds CAPACITY rates without overflow
    localparam int SUM_W      = IDX_W + RATE_W;

    // shared multiplier and square accumulators
    localparam int OPND_W     = 18;
    localparam int PROD_W     = 2 * OPND_W;
    localparam int ACC_W      = 34;

    // serial divider step counter
    localparam int DIV_CNT_W  = $clog2(SUM_W + 1);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOTION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE  = 2'd2;

    localparam logic [WGT_W-1:0] SMOOTH_RST = 8'd102;
    localparam logic [LIM_W-1:0] MOTION_RST = 15'd1787;
    localparam logic [LIM_W-1:0] NOISE_RST  = 15'd72;

    // datapath operations
    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NONE      = 5'd0;
    localparam logic [OP_W-1:0] OP_LOAD      = 5'd1;
    localparam logic [OP_W-1:0] OP_AVG_RAW   = 5'd2;
    localparam logic [OP_W-1:0] OP_RD_LAST   = 5'd3;
    localparam logic [OP_W-1:0] OP_SM_MUL    = 5'd4;
    localparam logic [OP_W-1:0] OP_SM_ADD    = 5'd5;
    localparam logic [OP_W-1:0] OP_DIV_START = 5'd6;
    localparam logic [OP_W-1:0] OP_MEAN_WR   = 5'd7;
    localparam logic [OP_W-1:0] OP_SQ_MUL    = 5'd8;
    localparam logic [OP_W-1:0] OP_SQ_ACC    = 5'd9;
    localparam logic [OP_W-1:0] OP_CLEAR     = 5'd10;
    localparam logic [OP_W-1:0] OP_RD_OLD    = 5'd11;
    localparam logic [OP_W-1:0] OP_PUSH      = 5'd12;
    localparam logic [OP_W-1:0] OP_BIAS_WR   = 5'd13;
    localparam logic [OP_W-1:0] OP_OUT       = 5'd14;

    // step index: axis, or square/limit step 0..7
    localparam int STEP_W = 3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [STEP_W-1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic count_zero;
        logic ring_full;
        logic bias_due;
        logic div_busy;
        logic out_free;
    } stat_t;

endpackage

// ===== rtl/core/gsb_sample_if.sv =====
// ----------------------------------------------------------------------------
// gsb_sample_if
// Input channel: one gyro sample word with temperature.
// ----------------------------------------------------------------------------
interface gsb_sample_if;
    logic                valid;
    logic                ready;
    logic signed [15:0]  rate_x;
    logic signed [15:0]  rate_y;
    logic signed [15:0]  rate_z;
    logic signed [15:0]  temperature;

    modport source (output valid, rate_x, rate_y, rate_z, temperature, input ready);
    modport sink   (input valid, rate_x, rate_y, rate_z, temperature, output ready);
endinterface

// ===== rtl/core/gsb_result_if.sv =====
// ----------------------------------------------------------------------------
// gsb_result_if
// Output channel: one bias estimate word per sample.
// ----------------------------------------------------------------------------
interface gsb_result_if;
    logic                valid;
    logic                ready;
    logic signed [15:0]  bias_x;
    logic signed [15:0]  bias_y;
    logic signed [15:0]  bias_z;
    logic signed [15:0]  bias_temperature;
    logic                bias_valid;
    logic                motion_seen;
    logic [10:0]         fill_count;
    logic                history_full;

    modport source (output valid, bias_x, bias_y, bias_z, bias_temperature, bias_valid,
                    motion_seen, fill_count, history_full, input ready);
    modport sink   (input valid, bias_x, bias_y, bias_z, bias_temperature, bias_valid,
                    motion_seen, fill_count, history_full, output ready);
endinterface

// ===== rtl/core/gsb_cfg_if.sv =====
// ----------------------------------------------------------------------------
// gsb_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface gsb_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/gsb_div.sv =====
// ----------------------------------------------------------------------------
// gsb_div
// Restoring divider, one quotient bit per cycle for a SUM_W-bit quotient.
// ----------------------------------------------------------------------------
module gsb_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [gsb_pkg::SUM_W-1:0]   dividend,
    input  logic [gsb_pkg::CNT_W-1:0]   divisor,
    output logic                        busy,
    output logic [gsb_pkg::SUM_W-1:0]   quotient
);
    import gsb_pkg::*;

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] step_reg;
    logic [SUM_W-1:0]     work_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic [CNT_W-1:0]     dsr_reg;

    logic [CNT_W:0]       trial;
    logic [CNT_W:0]       trial_sub;
    logic                 qbit;

    // trial subtract of the next partial remainder
    always_comb
    begin
        trial     = {rem_reg, work_reg[SUM_W-1]};
        trial_sub = trial - {1'b0, dsr_reg};
        qbit      = (trial >= {1'b0, dsr_reg});
    end

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= DIV_CNT_W'(SUM_W);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // remainder and dividend/quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= dividend;
            rem_reg  <= '0;
            dsr_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            work_reg <= {work_reg[SUM_W-2:0], qbit};
            rem_reg  <= qbit ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
        end
    end

    assign busy     = busy_reg;
    assign quotient = work_reg;

endmodule

// ===== rtl/core/gsb_datapath.sv =====
// ----------------------------------------------------------------------------
// gsb_datapath
// History ring, running sums, shared multiplier, serial divider, limit
// compares, configuration registers and the output word register.
// ----------------------------------------------------------------------------
module gsb_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  gsb_pkg::cmd_t                    cmd,
    output gsb_pkg::stat_t                   stat,
    input  logic signed [15:0]               rate_x,
    input  logic signed [15:0]               rate_y,
    input  logic signed [15:0]               rate_z,
    input  logic signed [15:0]               temperature,
    input  logic                             cfg_valid,
    input  logic [gsb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gsb_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [15:0]               bias_x,
    output logic signed [15:0]               bias_y,
    output logic signed [15:0]               bias_z,
    output logic signed [15:0]               bias_temperature,
    output logic                             bias_valid,
    output logic                             motion_seen,
    output logic [gsb_pkg::FILL_W-1:0]       fill_count,
    output logic                             history_full
);
    import gsb_pkg::*;

    localparam logic signed [SUM_W:0] RATE_MAX = (SUM_W+1)'(32767);
    localparam logic signed [SUM_W:0] RATE_MIN = (SUM_W+1)'(-32768);
    localparam logic [IDX_W-1:0]      HEAD_TOP = IDX_W'(CAPACITY - 1);

    function automatic logic signed [RATE_W-1:0] sat_rate(input logic signed [SUM_W:0] v);
        logic signed [RATE_W-1:0] r;
        if (v > RATE_MAX)
            r = RATE_W'(32767);
        else if (v < RATE_MIN)
            r = RATE_W'(-32768);
        else
            r = v[RATE_W-1:0];
        return r;
    endfunction

    // configuration
    logic [WGT_W-1:0] wgt_reg;
    logic [LIM_W-1:0] mlim_reg;
    logic [LIM_W-1:0] nlim_reg;

    // history state
    logic [ENTRY_W-1:0]        ring [CAPACITY];
    logic [ENTRY_W-1:0]        rd_data_reg;
    logic [IDX_W-1:0]          head_reg;
    logic [CNT_W-1:0]          count_reg;
    logic signed [SUM_W-1:0]   sum_reg [3];
    logic signed [RATE_W-1:0]  bias_reg [3];
    logic signed [RATE_W-1:0]  bias_temp_reg;
    logic                      latched_reg;

    // per-sample working registers
    logic signed [RATE_W-1:0]  rate_reg [3];
    logic signed [RATE_W-1:0]  temp_reg;
    logic signed [RATE_W-1:0]  avg_reg [3];
    logic signed [RATE_W-1:0]  mean_reg [3];
    logic signed [PROD_W-1:0]  prod_reg;
    logic [ACC_W-1:0]          mag2_reg;
    logic [ACC_W-1:0]          dist2_reg;
    logic                      motion_reg;
    logic                      div_neg_reg;

    // output word
    logic                      out_valid_reg;
    logic signed [RATE_W-1:0]  out_bias_reg [3];
    logic signed [RATE_W-1:0]  out_temp_reg;
    logic                      out_latched_reg;
    logic                      out_motion_reg;
    logic [CNT_W-1:0]          out_count_reg;
    logic                      out_full_reg;

    logic [1:0]                ax;
    logic [1:0]                sq_ax;
    logic signed [RATE_W-1:0]  last_ax;
    logic signed [RATE_W-1:0]  old_ax [3];
    logic signed [OPND_W-1:0]  mul_a;
    logic signed [OPND_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [PROD_W-1:0]  smooth_sum;
    logic [IDX_W-1:0]          last_addr;
    logic                      ring_full;
    logic                      sum_neg;
    logic [SUM_W-1:0]          sum_mag;
    logic [SUM_W-1:0]          div_dividend;
    logic                      div_busy;
    logic [SUM_W-1:0]          div_q;
    logic signed [SUM_W:0]     div_signed;
    logic signed [RATE_W-1:0]  mean_val;
    logic [ENTRY_W-1:0]        push_entry;

    assign ax        = cmd.idx[1:0];
    assign last_addr = (head_reg == '0) ? HEAD_TOP : head_reg - 1'b1;
    assign ring_full = (count_reg >= CNT_W'(CAPACITY));
    assign last_ax   = rd_data_reg[ax*RATE_W +: RATE_W];
    assign push_entry = {avg_reg[2], avg_reg[1], avg_reg[0]};

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            old_ax[k] = rd_data_reg[k*RATE_W +: RATE_W];
        end
    end

    // axis used by the square and difference-square steps
    always_comb
    begin
        unique case (cmd.idx)
            3'd0, 3'd1, 3'd2: sq_ax = cmd.idx[1:0];
            3'd3, 3'd4, 3'd5: sq_ax = 2'(cmd.idx - 3'd3);
            default:          sq_ax = 2'd0;
        endcase
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_SM_MUL:
            begin
                mul_a = OPND_W'(rate_reg[ax]) - OPND_W'(last_ax);
                mul_b = OPND_W'(signed'({1'b0, wgt_reg}));
            end
            OP_SQ_MUL:
            begin
                unique case (cmd.idx)
                    3'd0, 3'd1, 3'd2:
                    begin
                        mul_a = OPND_W'(avg_reg[sq_ax]);
                        mul_b = OPND_W'(avg_reg[sq_ax]);
                    end
                    3'd3, 3'd4, 3'd5:
                    begin
                        mul_a = OPND_W'(avg_reg[sq_ax]) - OPND_W'(mean_reg[sq_ax]);
                        mul_b = OPND_W'(avg_reg[sq_ax]) - OPND_W'(mean_reg[sq_ax]);
                    end
                    3'd6:
                    begin
                        mul_a = OPND_W'(signed'({1'b0, mlim_reg}));
                        mul_b = OPND_W'(signed'({1'b0, mlim_reg}));
                    end
                    default:
                    begin
                        mul_a = OPND_W'(signed'({1'b0, nlim_reg}));
                        mul_b = OPND_W'(signed'({1'b0, nlim_reg}));
                    end
                endcase
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // last*256 + (rate-last)*w + 128, floor by 256 is a bit select
    assign smooth_sum = (PROD_W'(last_ax) <<< 8) + prod_reg + PROD_W'(128);

    // divider operands: rounded magnitude of the selected sum
    assign sum_neg      = sum_reg[ax][SUM_W-1];
    assign sum_mag      = sum_neg ? SUM_W'(-sum_reg[ax]) : SUM_W'(sum_reg[ax]);
    assign div_dividend = sum_mag + SUM_W'(count_reg >> 1);

    gsb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.op == OP_DIV_START),
        .dividend (div_dividend),
        .divisor  (count_reg),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign div_signed = div_neg_reg ? -(SUM_W+1)'(div_q) : (SUM_W+1)'(div_q);
    assign mean_val   = sat_rate(div_signed);

    // ring memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_PUSH)
        begin
            ring[head_reg] <= push_entry;
        end
        if (cmd.op == OP_RD_LAST)
        begin
            rd_data_reg <= ring[last_addr];
        end
        else if (cmd.op == OP_RD_OLD)
        begin
            rd_data_reg <= ring[head_reg];
        end
    end

    // history, bias, configuration and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wgt_reg       <= SMOOTH_RST;
            mlim_reg      <= MOTION_RST;
            nlim_reg      <= NOISE_RST;
            head_reg      <= '0;
            count_reg     <= '0;
            for (int k = 0; k < 3; k++)
            begin
                sum_reg[k]  <= '0;
                bias_reg[k] <= '0;
            end
            bias_temp_reg <= '0;
            latched_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_SMOOTH: wgt_reg  <= cfg_data[WGT_W-1:0];
                    REG_MOTION: mlim_reg <= cfg_data[LIM_W-1:0];
                    REG_NOISE:  nlim_reg <= cfg_data[LIM_W-1:0];
                    default:    ;
                endcase
            end

            if (cmd.op == OP_CLEAR && motion_reg)
            begin
                head_reg  <= '0;
                count_reg <= '0;
                for (int k = 0; k < 3; k++)
                begin
                    sum_reg[k] <= '0;
                end
            end

            if (cmd.op == OP_PUSH)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    sum_reg[k] <= sum_reg[k] + SUM_W'(avg_reg[k])
                                  - (ring_full ? SUM_W'(old_ax[k]) : SUM_W'(0));
                end
                if (!ring_full)
                begin
                    count_reg <= count_reg + 1'b1;
                end
                head_reg <= (head_reg == HEAD_TOP) ? '0 : head_reg + 1'b1;
            end

            if (cmd.op == OP_BIAS_WR)
            begin
                bias_reg[ax]  <= mean_val;
                bias_temp_reg <= temp_reg;
                latched_reg   <= 1'b1;
            end

            if (cmd.op == OP_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // per-sample working registers and output payload
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                rate_reg[0] <= rate_x;
                rate_reg[1] <= rate_y;
                rate_reg[2] <= rate_z;
                temp_reg    <= temperature;
                mag2_reg    <= '0;
                dist2_reg   <= '0;
                motion_reg  <= 1'b0;
            end
            OP_AVG_RAW:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    avg_reg[k]  <= rate_reg[k];
                    mean_reg[k] <= '0;
                end
            end
            OP_SM_MUL, OP_SQ_MUL:
            begin
                prod_reg <= mul_p;
            end
            OP_SM_ADD:
            begin
                avg_reg[ax] <= smooth_sum[RATE_W+7:8];
            end
            OP_DIV_START:
            begin
                div_neg_reg <= sum_neg;
            end
            OP_MEAN_WR:
            begin
                mean_reg[ax] <= mean_val;
            end
            OP_SQ_ACC:
            begin
                unique case (cmd.idx)
                    3'd0, 3'd1, 3'd2: mag2_reg  <= mag2_reg + ACC_W'(prod_reg[32:0]);
                    3'd3, 3'd4, 3'd5: dist2_reg <= dist2_reg + ACC_W'(prod_reg[32:0]);
                    3'd6:
                    begin
                        if (mag2_reg >= ACC_W'(prod_reg[32:0]))
                            motion_reg <= 1'b1;
                    end
                    default:
                    begin
                        if (dist2_reg >= ACC_W'(prod_reg[32:0]))
                            motion_reg <= 1'b1;
                    end
                endcase
            end
            OP_OUT:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    out_bias_reg[k] <= bias_reg[k];
                end
                out_temp_reg    <= bias_temp_reg;
                out_latched_reg <= latched_reg;
                out_motion_reg  <= motion_reg;
                out_count_reg   <= count_reg;
                out_full_reg    <= ring_full;
            end
            default: ;
        endcase
    end

    // status to the controller
    always_comb
    begin
        stat.count_zero = (count_reg == '0);
        stat.ring_full  = ring_full;
        stat.bias_due   = (count_reg > CNT_W'(CAPACITY / 2));
        stat.div_busy   = div_busy;
        stat.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid        = out_valid_reg;
    assign bias_x           = out_bias_reg[0];
    assign bias_y           = out_bias_reg[1];
    assign bias_z           = out_bias_reg[2];
    assign bias_temperature = out_temp_reg;
    assign bias_valid       = out_latched_reg;
    assign motion_seen      = out_motion_reg;
    assign fill_count       = FILL_W'(out_count_reg);
    assign history_full     = out_full_reg;

endmodule

// ===== rtl/core/gsb_ctrl.sv =====
// ----------------------------------------------------------------------------
// gsb_ctrl
// Sequencer for one sample: smoothing, means, squares and limits,
// history update, bias latch and result word.
// ----------------------------------------------------------------------------
module gsb_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  gsb_pkg::stat_t  stat,
    output gsb_pkg::cmd_t   cmd
);
    import gsb_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RAW  = 4'd1;
    localparam logic [3:0] S_RDL  = 4'd2;
    localparam logic [3:0] S_SMM  = 4'd3;
    localparam logic [3:0] S_SMA  = 4'd4;
    localparam logic [3:0] S_DVM  = 4'd5;
    localparam logic [3:0] S_DWM  = 4'd6;
    localparam logic [3:0] S_SQM  = 4'd7;
    localparam logic [3:0] S_SQA  = 4'd8;
    localparam logic [3:0] S_CLR  = 4'd9;
    localparam logic [3:0] S_RDO  = 4'd10;
    localparam logic [3:0] S_PUSH = 4'd11;
    localparam logic [3:0] S_BCHK = 4'd12;
    localparam logic [3:0] S_DVB  = 4'd13;
    localparam logic [3:0] S_DWB  = 4'd14;
    localparam logic [3:0] S_OUT  = 4'd15;

    localparam logic [STEP_W-1:0] AXIS_LAST = 3'd2;
    localparam logic [STEP_W-1:0] SQ_LAST   = 3'd7;

    logic [3:0]        state_reg, state_next;
    logic [STEP_W-1:0] idx_reg, idx_next;

    // next state and command
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd.op     = OP_NONE;
        cmd.idx    = idx_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                idx_next = '0;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = stat.count_zero ? S_RAW : S_RDL;
                end
            end
            S_RAW:
            begin
                cmd.op     = OP_AVG_RAW;
                state_next = S_SQM;
            end
            S_RDL:
            begin
                cmd.op     = OP_RD_LAST;
                state_next = S_SMM;
            end
            S_SMM:
            begin
                cmd.op     = OP_SM_MUL;
                state_next = S_SMA;
            end
            S_SMA:
            begin
                cmd.op = OP_SM_ADD;
                if (idx_reg == AXIS_LAST)
                begin
                    idx_next   = '0;
                    state_next = S_DVM;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SMM;
                end
            end
            S_DVM:
            begin
                cmd.op     = OP_DIV_START;
                state_next = S_DWM;
            end
            S_DWM:
            begin
                if (!stat.div_busy)
                begin
                    cmd.op = OP_MEAN_WR;
                    if (idx_reg == AXIS_LAST)
                    begin
                        idx_next   = '0;
                        state_next = S_SQM;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_DVM;
                    end
                end
            end
            S_SQM:
            begin
                cmd.op     = OP_SQ_MUL;
                state_next = S_SQA;
            end
            S_SQA:
            begin
                cmd.op = OP_SQ_ACC;
                if (idx_reg == SQ_LAST)
                begin
                    idx_next   = '0;
                    state_next = S_CLR;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SQM;
                end
            end
            S_CLR:
            begin
                cmd.op     = OP_CLEAR;
                state_next = S_RDO;
            end
            S_RDO:
            begin
                cmd.op     = OP_RD_OLD;
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                cmd.op     = OP_PUSH;
                state_next = S_BCHK;
            end
            S_BCHK:
            begin
                idx_next   = '0;
                state_next = stat.bias_due ? S_DVB : S_OUT;
            end
            S_DVB:
            begin
                cmd.op     = OP_DIV_START;
                state_next = S_DWB;
            end
            S_DWB:
            begin
                if (!stat.div_busy)
                begin
                    cmd.op = OP_BIAS_WR;
                    if (idx_reg == AXIS_LAST)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_DVB;
                    end
                end
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// ===== rtl/core/gyro_still_bias_estimator.sv =====
// ----------------------------------------------------------------------------
// gyro_still_bias_estimator
// Zero-rate bias estimator for a three-axis gyro from still periods.
// ----------------------------------------------------------------------------
// One sample word in gives one result word out. Samples are handled one at a
// time. With an empty history a sample skips the smoothing and the means;
// otherwise the serial divider, which produces one quotient bit per cycle,
// runs three times for the history mean, and three more times for the bias
// once the ring holds more than half its capacity and the bias is latched.
// The result word sits in an output register, so the next sample is taken
// while it waits. Configuration writes are always ready and are meant for idle
// periods. The ring memory is not cleared after reset; only pushed entries
// are ever used.
module gyro_still_bias_estimator (
    input  logic          clk,
    input  logic          rst_n,
    gsb_sample_if.sink    sample,
    gsb_result_if.source  result,
    gsb_cfg_if.sink       cfg
);
    import gsb_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic  in_ready;

    assign sample.ready = in_ready;
    assign cfg.ready    = 1'b1;

    // sequencer
    gsb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // arithmetic and storage
    gsb_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .rate_x           (sample.rate_x),
        .rate_y           (sample.rate_y),
        .rate_z           (sample.rate_z),
        .temperature      (sample.temperature),
        .cfg_valid        (cfg.valid),
        .cfg_index        (cfg.index),
        .cfg_data         (cfg.data),
        .out_valid        (result.valid),
        .out_ready        (result.ready),
        .bias_x           (result.bias_x),
        .bias_y           (result.bias_y),
        .bias_z           (result.bias_z),
        .bias_temperature (result.bias_temperature),
        .bias_valid       (result.bias_valid),
        .motion_seen      (result.motion_seen),
        .fill_count       (result.fill_count),
        .history_full     (result.history_full)
    );

endmodule

// ===== rtl/core/gsb_checker.sv =====
// ----------------------------------------------------------------------------
// gsb_checker
// Port-level checks on the bias estimator, bound to the top level.
// ----------------------------------------------------------------------------
module gsb_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic signed [15:0]          bias_x,
    input  logic signed [15:0]          bias_y,
    input  logic signed [15:0]          bias_z,
    input  logic                        bias_valid,
    input  logic                        motion_seen,
    input  logic [gsb_pkg::FILL_W-1:0]  fill_count,
    input  logic                        history_full
);
    import gsb_pkg::*;

    // one sample in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("sample taken while another is in work");

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(fill_count) && $stable(bias_x))
        else $error("result word changed under stall");

    // motion leaves only the new sample in the history
    a_motion_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && motion_seen |-> fill_count == FILL_W'(1) && !history_full)
        else $error("motion word with wrong fill count");

    // full flag agrees with fill count
    a_full_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && history_full |-> fill_count == FILL_W'(CAPACITY))
        else $error("full flag without full count");

    // no bias before the first latch
    a_bias_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !bias_valid |-> bias_x == '0 && bias_y == '0 && bias_z == '0)
        else $error("bias nonzero before latch");

endmodule

bind gyro_still_bias_estimator gsb_checker u_gsb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (sample.valid),
    .in_ready     (sample.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .bias_x       (result.bias_x),
    .bias_y       (result.bias_y),
    .bias_z       (result.bias_z),
    .bias_valid   (result.bias_valid),
    .motion_seen  (result.motion_seen),
    .fill_count   (result.fill_count),
    .history_full (result.history_full)
);

// ===== dv/gsb_tb_if.sv =====
// ----------------------------------------------------------------------------
// gsb_tb_if
// Testbench-side channel bundles. The block's own interface files are
// reused directly; this file only hosts the sample and bias word structs used by
// the testbench, so that the interfaces keep a file of their own.
// ----------------------------------------------------------------------------
package gsb_tb_pkg;

    // one gyro sample word
    typedef struct {
        logic signed [15:0] rx;
        logic signed [15:0] ry;
        logic signed [15:0] rz;
        logic signed [15:0] temp;
    } sample_word_t;

    // one bias result word
    typedef struct {
        logic signed [15:0] bx;
        logic signed [15:0] by;
        logic signed [15:0] bz;
        logic signed [15:0] btemp;
        logic               bvalid;
        logic               motion;
        logic [10:0]        fill;
        logic               full;
    } bias_word_t;

endpackage

// ===== dv/gyro_still_bias_estimator_tb.sv =====
// ----------------------------------------------------------------------------
// gyro_still_bias_estimator_tb
// Drives gyro sample words into the bias estimator under random idling and
// back-pressure, predicts every bias result word with an independent
// fixed-point model of the smoothing, motion test, ring and mean, and
// compares each result word field by field.
// ----------------------------------------------------------------------------
module gyro_still_bias_estimator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gsb_pkg::*;
    import gsb_tb_pkg::*;

    logic clk;
    logic rst_n;

    gsb_sample_if sample ();
    gsb_result_if result ();
    gsb_cfg_if    cfg ();

    gyro_still_bias_estimator DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample.sink),
        .result (result.source),
        .cfg    (cfg.sink)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // predictor state
    logic signed [15:0] hist_ring [CAPACITY];
    logic signed [15:0] hist_ring_y [CAPACITY];
    logic signed [15:0] hist_ring_z [CAPACITY];
    int unsigned        head_ptr;
    int unsigned        hist_cnt;
    longint             sum_x, sum_y, sum_z;
    logic signed [15:0] bias_x_q, bias_y_q, bias_z_q, bias_t_q;
    logic               bias_set;
    logic [7:0]         weight_q;
    logic [14:0]        motion_lim_q;
    logic [14:0]        noise_lim_q;

    bias_word_t expected_biases[$];
    bit         failed;
    int         send_idle_pct;
    int         recv_idle_pct;
    bit         recv_hold;

    function automatic longint floor256(longint a);
        if (a >= 0)
            return a / 256;
        return -((-a + 255) / 256);
    endfunction

    function automatic longint hist_mean(longint s, int unsigned n);
        longint m;
        longint q;
        if (n == 0)
            return 0;
        m = (s < 0) ? -s : s;
        q = (m + n / 2) / n;
        q = (s < 0) ? -q : q;
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return q;
    endfunction

    function automatic longint smooth_axis(longint r, longint prev);
        return floor256(r * weight_q + prev * (256 - weight_q) + 128);
    endfunction

    // predict one bias word from one sample word
    function automatic bias_word_t predict_bias(sample_word_t s);
        bias_word_t b;
        longint ax, ay, az, mx, my, mz, mag2, dist2;
        int unsigned last;
        logic mot;
        if (hist_cnt == 0)
        begin
            ax = s.rx;
            ay = s.ry;
            az = s.rz;
        end
        else
        begin
            last = (head_ptr == 0) ? CAPACITY - 1 : head_ptr - 1;
            ax = smooth_axis(s.rx, hist_ring[last]);
            ay = smooth_axis(s.ry, hist_ring_y[last]);
            az = smooth_axis(s.rz, hist_ring_z[last]);
        end
        mx = hist_mean(sum_x, hist_cnt);
        my = hist_mean(sum_y, hist_cnt);
        mz = hist_mean(sum_z, hist_cnt);
        mag2 = ax * ax + ay * ay + az * az;
        dist2 = (ax - mx) * (ax - mx) + (ay - my) * (ay - my) + (az - mz) * (az - mz);
        mot = (mag2 >= longint'(motion_lim_q) * motion_lim_q)
            || (dist2 >= longint'(noise_lim_q) * noise_lim_q);
        if (mot)
        begin
            head_ptr = 0;
            hist_cnt = 0;
            sum_x = 0;
            sum_y = 0;
            sum_z = 0;
        end
        // full ring drops its oldest entry
        if (hist_cnt >= CAPACITY)
        begin
            sum_x -= hist_ring[head_ptr];
            sum_y -= hist_ring_y[head_ptr];
            sum_z -= hist_ring_z[head_ptr];
        end
        else
            hist_cnt++;
        hist_ring[head_ptr] = 16'(ax);
        hist_ring_y[head_ptr] = 16'(ay);
        hist_ring_z[head_ptr] = 16'(az);
        sum_x += ax;
        sum_y += ay;
        sum_z += az;
        head_ptr = (head_ptr + 1 >= CAPACITY) ? 0 : head_ptr + 1;
        if (hist_cnt > CAPACITY / 2)
        begin
            bias_x_q = 16'(hist_mean(sum_x, hist_cnt));
            bias_y_q = 16'(hist_mean(sum_y, hist_cnt));
            bias_z_q = 16'(hist_mean(sum_z, hist_cnt));
            bias_t_q = s.temp;
            bias_set = 1'b1;
        end
        b.bx = bias_x_q;
        b.by = bias_y_q;
        b.bz = bias_z_q;
        b.btemp = bias_t_q;
        b.bvalid = bias_set;
        b.motion = mot;
        b.fill = hist_cnt[10:0];
        b.full = hist_cnt >= CAPACITY;
        return b;
    endfunction

    // send one sample word
    task automatic send_sample(logic signed [15:0] rx, logic signed [15:0] ry,
                               logic signed [15:0] rz, logic signed [15:0] t);
        sample_word_t s;
        s.rx = rx;
        s.ry = ry;
        s.rz = rz;
        s.temp = t;
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample.valid <= 1'b0;
            @(posedge clk);
        end
        sample.valid <= 1'b1;
        sample.rate_x <= rx;
        sample.rate_y <= ry;
        sample.rate_z <= rz;
        sample.temperature <= t;
        do
            @(posedge clk);
        while (!sample.ready);
        expected_biases.push_back(predict_bias(s));
        sample.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        if (idx == REG_SMOOTH)
            weight_q = val[7:0];
        else if (idx == REG_MOTION)
            motion_lim_q = val[14:0];
        else if (idx == REG_NOISE)
            noise_lim_q = val[14:0];
        @(posedge clk);
    endtask

    // wait until all results are in, plus the block's settle time
    task automatic drain_results();
        while (expected_biases.size() != 0)
            @(posedge clk);
        repeat (250) @(posedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        bias_word_t e;
        if (rst_n && result.valid && result.ready)
        begin
            if (expected_biases.size() == 0)
            begin
                $display("%0t: unexpected result word, fill %0d", $realtime,
                         result.fill_count);
                failed = 1'b1;
            end
            else
            begin
                e = expected_biases.pop_front();
                if (result.bias_x !== e.bx || result.bias_y !== e.by
                    || result.bias_z !== e.bz || result.bias_temperature !== e.btemp
                    || result.bias_valid !== e.bvalid || result.motion_seen !== e.motion
                    || result.fill_count !== e.fill || result.history_full !== e.full)
                begin
                    $display("%0t: expected bias %0d %0d %0d t %0d v %0b m %0b f %0d h %0b",
                             $realtime, e.bx, e.by, e.bz, e.btemp, e.bvalid, e.motion,
                             e.fill, e.full);
                    $display("%0t: actual   bias %0d %0d %0d t %0d v %0b m %0b f %0d h %0b",
                             $realtime, result.bias_x, result.bias_y, result.bias_z,
                             result.bias_temperature, result.bias_valid,
                             result.motion_seen, result.fill_count, result.history_full);
                    failed = 1'b1;
                end
            end
        end
    end

    // receiver idling and long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            result.ready <= 1'b0;
        else
            result.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic test_directed();
        write_reg(REG_MOTION, 16'h7fff);
        write_reg(REG_NOISE, 16'h7fff);
        send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_sample(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000);
        send_sample(0, 0, 0, 0);
        send_sample(16'sh7fff, -16'sh8000, 16'sh5555, 16'sh2aaa);
        drain_results();
        // extreme weights and limits
        write_reg(REG_SMOOTH, 16'h00ff);
        send_sample(16'sh7fff, 0, -16'sh8000, 1);
        drain_results();
        write_reg(REG_SMOOTH, 16'h0000);
        send_sample(-16'sh8000, 16'sh7fff, 0, -1);
        drain_results();
        write_reg(REG_SMOOTH, 16'hff00);
        write_reg(REG_MOTION, 16'h0000);
        write_reg(REG_NOISE, 16'h0000);
        send_sample(0, 0, 0, 5);
        send_sample(3, -3, 1, 6);
        drain_results();
        write_reg(2'd3, 16'hffff);
        write_reg(REG_MOTION, 16'h8000);
        write_reg(REG_NOISE, 16'h8000);
        send_sample(1, 1, 1, 7);
        send_sample(-2, 0, 2, 8);
        drain_results();
    endtask

    // still runs with occasional wild samples; long runs latch a bias
    task automatic test_still_runs(int count, int spread, int wild_pct);
        int bx, by, bz;
        bx = $urandom_range(400) - 200;
        by = $urandom_range(400) - 200;
        bz = $urandom_range(400) - 200;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < wild_pct)
                send_sample(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            else
                send_sample(16'(bx + int'($urandom_range(2 * spread)) - spread),
                            16'(by + int'($urandom_range(2 * spread)) - spread),
                            16'(bz + int'($urandom_range(2 * spread)) - spread),
                            16'($urandom));
        end
    endtask

    task automatic test_back_pressure();
        recv_hold = 1'b1;
        fork
            begin
                repeat (3000) @(posedge clk);
                recv_hold = 1'b0;
            end
            test_still_runs(12, 4, 2);
        join
        drain_results();
    endtask

    initial
    begin
        failed = 1'b0;
        recv_hold = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n = 1'b0;
        sample.valid = 1'b0;
        sample.rate_x = '0;
        sample.rate_y = '0;
        sample.rate_z = '0;
        sample.temperature = '0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            hist_ring[i] = '0;
            hist_ring_y[i] = '0;
            hist_ring_z[i] = '0;
        end
        head_ptr = 0;
        hist_cnt = 0;
        sum_x = 0;
        sum_y = 0;
        sum_z = 0;
        bias_x_q = '0;
        bias_y_q = '0;
        bias_z_q = '0;
        bias_t_q = '0;
        bias_set = 1'b0;
        weight_q = SMOOTH_RST;
        motion_lim_q = MOTION_RST;
        noise_lim_q = NOISE_RST;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        // reset settings; sender idles 23 percent, receiver 49
        write_reg(REG_SMOOTH, 16'd102);
        write_reg(REG_MOTION, 16'd1787);
        write_reg(REG_NOISE, 16'd72);
        send_idle_pct = 23;
        recv_idle_pct = 49;
        test_still_runs(200, 3, 2);
        drain_results();
        // loose noise limit lets the ring pass half and latch a bias
        write_reg(REG_NOISE, 16'd2000);
        write_reg(REG_SMOOTH, 16'd255);
        send_idle_pct = 49;
        recv_idle_pct = 23;
        test_still_runs(600, 40, 0);
        drain_results();
        test_back_pressure();
        write_reg(REG_NOISE, 16'd60);
        write_reg(REG_SMOOTH, 16'd30);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_still_runs(130, 2, 2);
        drain_results();

        if (!failed)
            $display("gyro_still_bias_estimator_tb passed");
        else
            $display("gyro_still_bias_estimator_tb failed");
        $finish;
    end

    // run limit
    initial
    begin
        #3000000;
        $display("gyro_still_bias_estimator_tb failed");
        $finish;
    end

endmodule
